/* src/lqrsg_pkg.sv */
package lqrsg_pkg;

	// Window geometry
	localparam int TAPS = 11;
	localparam int PTR_W = $clog2(TAPS);
	localparam int ANG_W = 20;

	// Shared multiplier and accumulator widths
	localparam int A_W = 26;
	localparam int B_W = 25;
	localparam int P_W = A_W + B_W;
	localparam int ACC_W = 64;

	// Negated feedback sum, clamped so that the torque product splits in two halves
	localparam int N_W = 37;
	localparam int N_SPLIT = 18;

	// Configuration port
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 24;

	typedef logic [PTR_W-1:0] ptr_t;
	typedef logic [CFG_IDX_W-1:0] reg_idx_t;

	localparam reg_idx_t REG_GAIN_POS = 3'd0;
	localparam reg_idx_t REG_GAIN_VEL = 3'd1;
	localparam reg_idx_t REG_GAIN_ANG = 3'd2;
	localparam reg_idx_t REG_GAIN_RATE = 3'd3;
	localparam reg_idx_t REG_HOME = 3'd4;
	localparam reg_idx_t REG_RADIUS = 3'd5;
	localparam reg_idx_t REG_TORQUE_LIM = 3'd6;
	localparam reg_idx_t REG_CART_LIM = 3'd7;

	// pi/180 in Q25
	localparam logic signed [B_W-1:0] DEG_TO_RAD_Q25 = 25'sd585635;
	// 1e-5 rad/s in Q31
	localparam logic signed [ACC_W-1:0] RATE_DEADBAND = 64'sd21475;
	localparam logic signed [ACC_W-1:0] RATE_MAX = 64'sd8388607;
	localparam logic signed [ACC_W-1:0] RATE_MIN = -64'sd8388608;
	localparam logic signed [ACC_W-1:0] U_MAX = (64'sd1 <<< (N_W - 1)) - 64'sd1;

	typedef struct packed {
		logic signed [23:0] gain_cart_pos;
		logic signed [23:0] gain_cart_vel;
		logic signed [23:0] gain_pole_ang;
		logic signed [23:0] gain_pole_rate;
		logic signed [23:0] home_offset;
		logic [15:0] pulley_radius;
		logic [14:0] torque_limit;
		logic [15:0] cart_limit;
	} cfg_t;

	localparam cfg_t RESET_CFG = '{
		gain_cart_pos: 24'sd114487,
		gain_cart_vel: 24'sd157053,
		gain_pole_ang: 24'sd888199,
		gain_pole_rate: 24'sd25623,
		home_offset: 24'sd0,
		pulley_radius: 16'd1671,
		torque_limit: 15'd12288,
		cart_limit: 16'd13763
	};

	// Window memory requests from the sequencer
	typedef struct packed {
		logic rd_newest;
		logic rd_step;
		logic wr_en;
		logic signed [ANG_W-1:0] wr_data;
	} win_ctl_t;

	// Accumulator operation, applied in the cycle after the multiply
	typedef logic [1:0] acc_mode_t;
	localparam acc_mode_t ACC_HOLD = 2'd0;
	localparam acc_mode_t ACC_LOAD = 2'd1;
	localparam acc_mode_t ACC_ADD = 2'd2;

	typedef logic [1:0] acc_sh_t;
	localparam acc_sh_t SH_0 = 2'd0;
	localparam acc_sh_t SH_1 = 2'd1;
	localparam acc_sh_t SH_4 = 2'd2;
	localparam acc_sh_t SH_SPLIT = 2'd3;

	typedef struct packed {
		acc_mode_t mode;
		acc_sh_t sh;
	} mac_op_t;

	function automatic ptr_t ptr_inc(input ptr_t p);
		return (p == ptr_t'(TAPS - 1)) ? '0 : p + ptr_t'(1);
	endfunction

	function automatic ptr_t ptr_dec(input ptr_t p);
		return (p == '0) ? ptr_t'(TAPS - 1) : p - ptr_t'(1);
	endfunction

	// Round to nearest with halves up, then drop s fraction bits
	function automatic logic signed [ACC_W-1:0] round_shr(
		input logic signed [ACC_W-1:0] v,
		input int unsigned s
	);
		logic signed [ACC_W-1:0] half;
		half = 64'sd1 <<< (s - 1);
		return (v + half) >>> s;
	endfunction

	// Derivative weights in Q16, oldest window entry first
	function automatic logic signed [B_W-1:0] sg_weight(input ptr_t idx);
		logic signed [B_W-1:0] w;
		unique case (idx)
			4'd0: w = 25'sd1909557;
			4'd1: w = -25'sd1871366;
			4'd2: w = -25'sd3386281;
			4'd3: w = -25'sd3201691;
			4'd4: w = -25'sd1884096;
			4'd5: w = 25'sd0;
			4'd6: w = 25'sd1884096;
			4'd7: w = 25'sd3201691;
			4'd8: w = 25'sd3386281;
			4'd9: w = 25'sd1871366;
			4'd10: w = -25'sd1909557;
			default: w = 25'sd0;
		endcase
		return w;
	endfunction

endpackage

/* src/lqrsg_regs.sv */
module lqrsg_regs (
	input logic clk,
	input logic arst_n,
	input logic we,
	input lqrsg_pkg::reg_idx_t index,
	input logic [lqrsg_pkg::CFG_DATA_W-1:0] data,
	output lqrsg_pkg::cfg_t cfg
);

	lqrsg_pkg::cfg_t regs_q;

	// Store each register at its own width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= lqrsg_pkg::RESET_CFG;
		end else if (we) begin
			unique case (index)
				lqrsg_pkg::REG_GAIN_POS: regs_q.gain_cart_pos <= data;
				lqrsg_pkg::REG_GAIN_VEL: regs_q.gain_cart_vel <= data;
				lqrsg_pkg::REG_GAIN_ANG: regs_q.gain_pole_ang <= data;
				lqrsg_pkg::REG_GAIN_RATE: regs_q.gain_pole_rate <= data;
				lqrsg_pkg::REG_HOME: regs_q.home_offset <= data;
				lqrsg_pkg::REG_RADIUS: regs_q.pulley_radius <= data[15:0];
				lqrsg_pkg::REG_TORQUE_LIM: regs_q.torque_limit <= data[14:0];
				lqrsg_pkg::REG_CART_LIM: regs_q.cart_limit <= data[15:0];
			endcase
		end
	end

	assign cfg = regs_q;

endmodule

/* src/lqrsg_window.sv */
module lqrsg_window (
	input logic clk,
	input logic arst_n,
	input lqrsg_pkg::win_ctl_t ctl,
	output logic signed [lqrsg_pkg::ANG_W-1:0] rd_data
);

	logic signed [lqrsg_pkg::ANG_W-1:0] mem [lqrsg_pkg::TAPS];
	logic signed [lqrsg_pkg::ANG_W-1:0] rd_q;
	logic [lqrsg_pkg::TAPS-1:0] vbit_q;
	logic rd_ok_q;
	lqrsg_pkg::ptr_t wp_q;
	lqrsg_pkg::ptr_t rp_q;
	lqrsg_pkg::ptr_t rd_addr;

	// Newest entry sits just behind the write pointer; taps walk from the read pointer
	assign rd_addr = ctl.rd_newest ? lqrsg_pkg::ptr_dec(wp_q) : rp_q;

	// Simple dual-port style array: one write and one registered read a cycle
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wp_q] <= ctl.wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	// Pointers and per-entry valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vbit_q <= '0;
			wp_q <= '0;
			rp_q <= '0;
			rd_ok_q <= 1'b0;
		end else begin
			rd_ok_q <= vbit_q[rd_addr];
			if (ctl.wr_en) begin
				vbit_q[wp_q] <= 1'b1;
				wp_q <= lqrsg_pkg::ptr_inc(wp_q);
			end
			if (ctl.rd_newest) begin
				rp_q <= lqrsg_pkg::ptr_inc(wp_q);
			end else if (ctl.rd_step) begin
				rp_q <= lqrsg_pkg::ptr_inc(rp_q);
			end
		end
	end

	// An entry never written reads as zero
	assign rd_data = rd_ok_q ? rd_q : '0;

endmodule

/* src/lqrsg_mac.sv */
module lqrsg_mac (
	input logic clk,
	input logic arst_n,
	input logic signed [lqrsg_pkg::A_W-1:0] a,
	input logic signed [lqrsg_pkg::B_W-1:0] b,
	input lqrsg_pkg::mac_op_t op,
	output logic signed [lqrsg_pkg::P_W-1:0] prod,
	output logic signed [lqrsg_pkg::ACC_W-1:0] acc
);

	logic signed [lqrsg_pkg::P_W-1:0] mul;
	logic signed [lqrsg_pkg::P_W-1:0] prod_s1;
	logic signed [lqrsg_pkg::ACC_W-1:0] ext;
	logic signed [lqrsg_pkg::ACC_W-1:0] addend;
	logic signed [lqrsg_pkg::ACC_W-1:0] acc_q;
	lqrsg_pkg::mac_op_t op_s1;

	assign mul = lqrsg_pkg::P_W'(a) * lqrsg_pkg::P_W'(b);
	assign ext = lqrsg_pkg::ACC_W'(prod_s1);

	// Align the product to the accumulator's binary point
	always_comb begin
		unique case (op_s1.sh)
			lqrsg_pkg::SH_0: addend = ext;
			lqrsg_pkg::SH_1: addend = ext <<< 1;
			lqrsg_pkg::SH_4: addend = ext <<< 4;
			lqrsg_pkg::SH_SPLIT: addend = ext <<< lqrsg_pkg::N_SPLIT;
		endcase
	end

	// Carry the operation alongside the product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= '{mode: lqrsg_pkg::ACC_HOLD, sh: lqrsg_pkg::SH_0};
		end else begin
			op_s1 <= op;
		end
	end

	// Register the product, then load or add it
	always_ff @(posedge clk) begin
		prod_s1 <= mul;
		unique case (op_s1.mode)
			lqrsg_pkg::ACC_LOAD: acc_q <= addend;
			lqrsg_pkg::ACC_ADD: acc_q <= acc_q + addend;
			default: acc_q <= acc_q;
		endcase
	end

	assign prod = prod_s1;
	assign acc = acc_q;

endmodule

/* src/lqr_balance_with_sg_rate_core.sv */
// Cart-pole balance controller: LQR state feedback with an 11-tap
// Savitzky-Golay pole-rate estimate, in fixed point.
// Input channel (in_valid/in_stall): one request per control tick carrying
// motor position, motor velocity, pole angle in degrees and angle_valid.
// Output channel (out_valid/out_stall): one result per request with the
// saturated torque, the clip flag, the cart fault and the pole rate.
// Configuration channel (cfg_valid/cfg_ready): cfg_ready is always high;
// write registers only while no request is in flight.
// The core takes no new request until the last one has been worked through,
// as the single shared multiplier (20 products) and the one-read-a-cycle
// angle window memory serve each request in turn.
// While the output register still holds an untaken result the next request
// is accepted and worked on; it waits in its last step if out_stall is high.
// Reset returns the configuration registers to their defaults and empties the
// window, whose entries then read as zero angle; no clearing pass is needed.
module lqr_balance_with_sg_rate_core (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic signed [23:0] motor_pos,
	input logic signed [23:0] motor_vel,
	input logic signed [15:0] pole_angle_deg,
	input logic angle_valid,
	output logic out_valid,
	input logic out_stall,
	output logic signed [15:0] torque_cmd,
	output logic torque_saturated,
	output logic cart_fault,
	output logic signed [23:0] pole_rate,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [lqrsg_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [lqrsg_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_NEW = 4'd1;
	localparam logic [3:0] S_ANG = 4'd2;
	localparam logic [3:0] S_TAP = 4'd3;
	localparam logic [3:0] S_TOP = 4'd4;
	localparam logic [3:0] S_VEL = 4'd5;
	localparam logic [3:0] S_RATE = 4'd6;
	localparam logic [3:0] S_KV = 4'd7;
	localparam logic [3:0] S_KA = 4'd8;
	localparam logic [3:0] S_KR = 4'd9;
	localparam logic [3:0] S_SUM = 4'd10;
	localparam logic [3:0] S_NEG = 4'd11;
	localparam logic [3:0] S_TLO = 4'd12;
	localparam logic [3:0] S_THI = 4'd13;
	localparam logic [3:0] S_TEND = 4'd14;
	localparam logic [3:0] S_DONE = 4'd15;

	localparam lqrsg_pkg::ptr_t LAST_TAP = lqrsg_pkg::ptr_t'(lqrsg_pkg::TAPS - 2);

	lqrsg_pkg::cfg_t cfg;
	lqrsg_pkg::win_ctl_t win_ctl;
	lqrsg_pkg::mac_op_t mac_op;

	logic [3:0] state_q, state_d;
	lqrsg_pkg::ptr_t tap_q;
	logic out_valid_q;
	logic out_free;

	// Captured request
	logic signed [23:0] pos_q;
	logic signed [23:0] vel_q;
	logic signed [15:0] deg_q;
	logic avalid_q;

	// Intermediate results
	logic signed [lqrsg_pkg::ANG_W-1:0] ang_q;
	logic signed [24:0] x16_q;
	logic signed [23:0] v16_q;
	logic signed [23:0] rate_q;
	logic signed [lqrsg_pkg::N_W-1:0] n_q;
	logic fault_q;

	// Output register
	logic signed [15:0] torque_q;
	logic sat_q;
	logic fault_out_q;
	logic signed [23:0] rate_out_q;

	logic signed [lqrsg_pkg::ANG_W-1:0] win_data;
	logic signed [lqrsg_pkg::A_W-1:0] mul_a;
	logic signed [lqrsg_pkg::B_W-1:0] mul_b;
	logic signed [lqrsg_pkg::P_W-1:0] prod;
	logic signed [lqrsg_pkg::ACC_W-1:0] acc;
	logic signed [lqrsg_pkg::ACC_W-1:0] prod64;
	logic signed [lqrsg_pkg::B_W-1:0] radius_b;
	logic signed [24:0] diff;
	logic signed [lqrsg_pkg::ANG_W-1:0] ang_new;
	logic signed [lqrsg_pkg::P_W-1:0] xp_mag;
	logic [lqrsg_pkg::P_W-1:0] cart_lim_q16;
	logic signed [lqrsg_pkg::ACC_W-1:0] rate_full;
	logic signed [23:0] rate_next;
	logic signed [lqrsg_pkg::ACC_W-1:0] u_full;
	logic signed [lqrsg_pkg::ACC_W-1:0] u_clamp;
	logic signed [lqrsg_pkg::ACC_W-1:0] t_full;
	logic signed [lqrsg_pkg::ACC_W-1:0] tlim_s;
	logic signed [15:0] torque_next;
	logic sat_next;

	assign cfg_ready = 1'b1;

	lqrsg_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.we(cfg_valid && cfg_ready),
		.index(cfg_index),
		.data(cfg_data),
		.cfg(cfg)
	);

	lqrsg_window u_window (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(win_ctl),
		.rd_data(win_data)
	);

	lqrsg_mac u_mac (
		.clk(clk),
		.arst_n(arst_n),
		.a(mul_a),
		.b(mul_b),
		.op(mac_op),
		.prod(prod),
		.acc(acc)
	);

	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign prod64 = lqrsg_pkg::ACC_W'(prod);
	assign radius_b = lqrsg_pkg::B_W'($signed({1'b0, cfg.pulley_radius}));
	assign diff = 25'(pos_q) - 25'(cfg.home_offset);

	// New window angle: converted reading, or the newest stored one again
	assign ang_new = avalid_q ? lqrsg_pkg::ANG_W'(lqrsg_pkg::round_shr(prod64, 16)) : win_data;

	// Cart displacement against the travel limit, exact on the Q32 product
	assign xp_mag = prod[lqrsg_pkg::P_W-1] ? -prod : prod;
	assign cart_lim_q16 = {{(lqrsg_pkg::P_W - 32){1'b0}}, cfg.cart_limit, 16'd0};

	// Pole rate: deadband, round to Q12, saturate
	always_comb begin
		rate_full = lqrsg_pkg::round_shr(acc, 19);
		if (acc > -lqrsg_pkg::RATE_DEADBAND && acc < lqrsg_pkg::RATE_DEADBAND) begin
			rate_next = '0;
		end else if (rate_full > lqrsg_pkg::RATE_MAX) begin
			rate_next = 24'(lqrsg_pkg::RATE_MAX);
		end else if (rate_full < lqrsg_pkg::RATE_MIN) begin
			rate_next = 24'(lqrsg_pkg::RATE_MIN);
		end else begin
			rate_next = 24'(rate_full);
		end
	end

	// Feedback sum to Q14, clamped where the torque saturates anyway
	always_comb begin
		u_full = lqrsg_pkg::round_shr(acc, 10);
		priority if (u_full > lqrsg_pkg::U_MAX) begin
			u_clamp = lqrsg_pkg::U_MAX;
		end else if (u_full < -lqrsg_pkg::U_MAX) begin
			u_clamp = -lqrsg_pkg::U_MAX;
		end else begin
			u_clamp = u_full;
		end
	end

	// Torque to Q10 and clip to the limit
	always_comb begin
		t_full = lqrsg_pkg::round_shr(acc, 20);
		tlim_s = lqrsg_pkg::ACC_W'($signed({1'b0, cfg.torque_limit}));
		priority if (t_full > tlim_s) begin
			torque_next = 16'(tlim_s);
			sat_next = 1'b1;
		end else if (t_full < -tlim_s) begin
			torque_next = 16'(-tlim_s);
			sat_next = 1'b1;
		end else begin
			torque_next = 16'(t_full);
			sat_next = 1'b0;
		end
	end

	// Multiplier operands, accumulator operation and window requests per step
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		mac_op = '{mode: lqrsg_pkg::ACC_HOLD, sh: lqrsg_pkg::SH_0};
		win_ctl = '{rd_newest: 1'b0, rd_step: 1'b0, wr_en: 1'b0, wr_data: ang_new};
		unique case (state_q)
			S_NEW: begin
				mul_a = lqrsg_pkg::A_W'(deg_q);
				mul_b = lqrsg_pkg::DEG_TO_RAD_Q25;
				win_ctl.rd_newest = 1'b1;
			end
			S_ANG: begin
				mul_a = lqrsg_pkg::A_W'(diff);
				mul_b = radius_b;
				win_ctl.wr_en = 1'b1;
				win_ctl.rd_step = 1'b1;
			end
			S_TAP: begin
				mul_a = lqrsg_pkg::A_W'(win_data);
				mul_b = lqrsg_pkg::sg_weight(tap_q);
				mac_op.mode = (tap_q == '0) ? lqrsg_pkg::ACC_LOAD : lqrsg_pkg::ACC_ADD;
				win_ctl.rd_step = (tap_q != LAST_TAP);
			end
			S_TOP: begin
				mul_a = lqrsg_pkg::A_W'(ang_q);
				mul_b = lqrsg_pkg::sg_weight(lqrsg_pkg::ptr_t'(lqrsg_pkg::TAPS - 1));
				mac_op.mode = lqrsg_pkg::ACC_ADD;
			end
			S_VEL: begin
				mul_a = lqrsg_pkg::A_W'(vel_q);
				mul_b = radius_b;
			end
			S_RATE: begin
				mul_a = lqrsg_pkg::A_W'(x16_q);
				mul_b = lqrsg_pkg::B_W'(cfg.gain_cart_pos);
				mac_op.mode = lqrsg_pkg::ACC_LOAD;
			end
			S_KV: begin
				mul_a = lqrsg_pkg::A_W'(v16_q);
				mul_b = lqrsg_pkg::B_W'(cfg.gain_cart_vel);
				mac_op.mode = lqrsg_pkg::ACC_ADD;
			end
			S_KA: begin
				mul_a = lqrsg_pkg::A_W'(ang_q);
				mul_b = lqrsg_pkg::B_W'(cfg.gain_pole_ang);
				mac_op = '{mode: lqrsg_pkg::ACC_ADD, sh: lqrsg_pkg::SH_1};
			end
			S_KR: begin
				mul_a = lqrsg_pkg::A_W'(rate_q);
				mul_b = lqrsg_pkg::B_W'(cfg.gain_pole_rate);
				mac_op = '{mode: lqrsg_pkg::ACC_ADD, sh: lqrsg_pkg::SH_4};
			end
			S_TLO: begin
				mul_a = lqrsg_pkg::A_W'($signed({1'b0, n_q[lqrsg_pkg::N_SPLIT-1:0]}));
				mul_b = radius_b;
				mac_op.mode = lqrsg_pkg::ACC_LOAD;
			end
			S_THI: begin
				mul_a = lqrsg_pkg::A_W'($signed(n_q[lqrsg_pkg::N_W-1:lqrsg_pkg::N_SPLIT]));
				mul_b = radius_b;
				mac_op = '{mode: lqrsg_pkg::ACC_ADD, sh: lqrsg_pkg::SH_SPLIT};
			end
			default: begin
			end
		endcase
	end

	// Step sequence
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (in_valid) state_d = S_NEW;
			S_NEW: state_d = S_ANG;
			S_ANG: state_d = S_TAP;
			S_TAP: if (tap_q == LAST_TAP) state_d = S_TOP;
			S_TOP: state_d = S_VEL;
			S_VEL: state_d = S_RATE;
			S_RATE: state_d = S_KV;
			S_KV: state_d = S_KA;
			S_KA: state_d = S_KR;
			S_KR: state_d = S_SUM;
			S_SUM: state_d = S_NEG;
			S_NEG: state_d = S_TLO;
			S_TLO: state_d = S_THI;
			S_THI: state_d = S_TEND;
			S_TEND: state_d = S_DONE;
			S_DONE: if (out_free) state_d = S_IDLE;
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			tap_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_ANG) begin
				tap_q <= '0;
			end else if (state_q == S_TAP) begin
				tap_q <= tap_q + lqrsg_pkg::ptr_t'(1);
			end
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			pos_q <= motor_pos;
			vel_q <= motor_vel;
			deg_q <= pole_angle_deg;
			avalid_q <= angle_valid;
		end
		if (state_q == S_ANG) begin
			ang_q <= ang_new;
		end
		if (state_q == S_TAP && tap_q == '0) begin
			x16_q <= 25'(lqrsg_pkg::round_shr(prod64, 16));
			fault_q <= $unsigned(xp_mag) > cart_lim_q16;
		end
		if (state_q == S_RATE) begin
			v16_q <= 24'(lqrsg_pkg::round_shr(prod64, 16));
			rate_q <= rate_next;
		end
		if (state_q == S_NEG) begin
			n_q <= lqrsg_pkg::N_W'(-u_clamp);
		end
		if (state_q == S_DONE && out_free) begin
			torque_q <= torque_next;
			sat_q <= sat_next;
			fault_out_q <= fault_q;
			rate_out_q <= rate_q;
		end
	end

	assign out_valid = out_valid_q;
	assign torque_cmd = torque_q;
	assign torque_saturated = sat_q;
	assign cart_fault = fault_out_q;
	assign pole_rate = rate_out_q;

endmodule

/* src/lqrsg_checker.sv */
module lqrsg_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input logic signed [23:0] motor_pos,
	input logic signed [23:0] motor_vel,
	input logic signed [15:0] pole_angle_deg,
	input logic angle_valid,
	input logic out_valid,
	input logic out_stall,
	input logic signed [15:0] torque_cmd,
	input logic torque_saturated,
	input logic cart_fault,
	input logic signed [23:0] pole_rate,
	input logic cfg_valid,
	input logic cfg_ready,
	input logic [lqrsg_pkg::CFG_IDX_W-1:0] cfg_index,
	input logic [lqrsg_pkg::CFG_DATA_W-1:0] cfg_data
);

	// One request at a time: the input stays busy after a request is accepted
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall ##1 in_stall)
		else $error("input taken again too soon after a request");

	// A new result only appears at the end of a request's work
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result raised while no request was in progress");

	// Idle with the result taken: nothing new can follow next cycle
	a_no_spurious_result: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !in_stall |=> !out_valid)
		else $error("result appeared without a request");

	// Held result keeps its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(torque_cmd) && $stable(pole_rate)
			&& $stable(torque_saturated) && $stable(cart_fault))
		else $error("stalled result changed");

endmodule

bind lqr_balance_with_sg_rate_core lqrsg_checker u_lqrsg_checker (.*);
